// File: rtl/bdpd_pkg.sv
// Shared types and constants for the button debounce and presence detect unit.
// Used by every module of the block; no dependencies of its own.
package bdpd_pkg;

    // Field widths
    localparam int NOW_BITS      = 32;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int BTN_COUNT     = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_BUTTON_HOLD = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLEAR       = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DETECT_HOLD = 2'd2;

    // Configuration reset values
    localparam logic [CFG_DATA_BITS-1:0] BUTTON_HOLD_RESET = 16'd15;
    localparam logic [CFG_DATA_BITS-1:0] CLEAR_RESET       = 16'd50;
    localparam logic [CFG_DATA_BITS-1:0] DETECT_HOLD_RESET = 16'd30;

    // One poll transaction
    typedef struct packed {
        logic                start_level;
        logic                stop_level;
        logic                clear_btn_level;
        logic                object_present;
        logic                run_mode;
        logic [NOW_BITS-1:0] now_tick;
    } poll_t;

    // One result transaction
    typedef struct packed {
        logic start_press;
        logic ev_stop;
        logic ev_clear_btn;
        logic area_empty;
        logic ev_object;
        logic armed_now;
    } result_t;

    // Per-poll control from the pipeline to the state holders
    typedef struct packed {
        logic advance;  // poll moves from input register to result register
        logic first;    // first poll after reset: load previous levels
    } poll_ctl_t;

endpackage

// File: rtl/button_debounce_presence_detect_unit.sv
// Top level: input register, three button debouncers, presence logic, result register.
// Depends on bdpd_pkg, bdpd_debounce and bdpd_presence.
//
//   Channel | Ports                                    | Direction
//   --------+------------------------------------------+----------
//   poll    | s_valid, s_ready, s_poll                 | in
//   result  | m_valid, m_ready, m_result               | out
//   config  | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// Each poll is captured in the input register and moves into the result register
// when that register is empty or being read; one poll per cycle is sustained
// while m_ready stays high.
// Reset (aresetn low, synchronous) clears the pipeline and loads the default
// config values; config writes are always accepted.
// A stalled result holds the pipeline; s_ready stays high while the input
// register is empty or can move forward.
module button_debounce_presence_detect_unit #(
    parameter int TICK_BITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  bdpd_pkg::poll_t                     s_poll,
    output logic                                m_valid,
    input  logic                                m_ready,
    output bdpd_pkg::result_t                   m_result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bdpd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [bdpd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    logic [bdpd_pkg::CFG_DATA_BITS-1:0] button_hold_reg;
    logic [bdpd_pkg::CFG_DATA_BITS-1:0] clear_reg;
    logic [bdpd_pkg::CFG_DATA_BITS-1:0] detect_hold_reg;

    logic                in_valid_reg;
    bdpd_pkg::poll_t     in_reg;
    logic                out_valid_reg;
    bdpd_pkg::result_t   result_reg, result_next;
    logic                primed_reg;
    logic                advance;
    bdpd_pkg::poll_ctl_t ctl;

    logic [TICK_BITS-1:0]           now;
    logic [bdpd_pkg::BTN_COUNT-1:0] levels;
    logic [bdpd_pkg::BTN_COUNT-1:0] presses;
    logic                           area_empty;
    logic                           ev_object;
    logic                           armed_now;

    // Pipeline handshake
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_result  = result_reg;
    assign cfg_ready = 1'b1;

    assign ctl = '{advance: advance, first: !primed_reg};

    // Fit the tick count to the counter width
    generate
        if (TICK_BITS <= bdpd_pkg::NOW_BITS) begin : g_now_trunc
            assign now = in_reg.now_tick[TICK_BITS-1:0];
        end else begin : g_now_ext
            assign now = {{(TICK_BITS - bdpd_pkg::NOW_BITS){1'b0}}, in_reg.now_tick};
        end
    endgenerate

    assign levels = {in_reg.clear_btn_level, in_reg.stop_level, in_reg.start_level};

    // Debounce each button
    generate
        for (genvar b = 0; b < bdpd_pkg::BTN_COUNT; b++) begin : g_btn
            bdpd_debounce #(
                .TICK_BITS (TICK_BITS)
            ) u_debounce (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctl        (ctl),
                .level      (levels[b]),
                .now        (now),
                .hold_ticks (button_hold_reg),
                .press      (presses[b])
            );
        end
    endgenerate

    bdpd_presence #(
        .TICK_BITS (TICK_BITS)
    ) u_presence (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .ctl               (ctl),
        .present           (in_reg.object_present),
        .run               (in_reg.run_mode),
        .now               (now),
        .clear_ticks       (clear_reg),
        .detect_hold_ticks (detect_hold_reg),
        .area_empty        (area_empty),
        .ev_object         (ev_object),
        .armed_now         (armed_now)
    );

    // Assemble the result
    always_comb begin
        result_next.start_press  = presses[0];
        result_next.ev_stop      = presses[1];
        result_next.ev_clear_btn = presses[2];
        result_next.area_empty   = area_empty;
        result_next.ev_object    = ev_object;
        result_next.armed_now    = armed_now;
    end

    // Pipeline control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            primed_reg    <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                primed_reg    <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_poll;
        end
        if (advance) begin
            result_reg <= result_next;
        end
    end

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            button_hold_reg <= bdpd_pkg::BUTTON_HOLD_RESET;
            clear_reg       <= bdpd_pkg::CLEAR_RESET;
            detect_hold_reg <= bdpd_pkg::DETECT_HOLD_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                bdpd_pkg::CFG_BUTTON_HOLD: button_hold_reg <= cfg_data;
                bdpd_pkg::CFG_CLEAR:       clear_reg       <= cfg_data;
                bdpd_pkg::CFG_DETECT_HOLD: detect_hold_reg <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// File: rtl/bdpd_debounce.sv
// Debounce state and decision logic for one push button.
// Depends on bdpd_pkg for the poll control struct and config width.
module bdpd_debounce #(
    parameter int TICK_BITS = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  bdpd_pkg::poll_ctl_t                ctl,
    input  logic                               level,
    input  logic [TICK_BITS-1:0]               now,
    input  logic [bdpd_pkg::CFG_DATA_BITS-1:0] hold_ticks,
    output logic                               press
);

    logic                 stable_reg, stable_next;
    logic                 pending_reg, pending_next;
    logic [TICK_BITS-1:0] start_reg, start_next;
    logic                 stable_eff;
    logic [TICK_BITS-1:0] elapsed;

    assign stable_eff = ctl.first ? level : stable_reg;
    assign elapsed    = now - start_reg;

    // Decide the pending interval and the new stable level
    always_comb begin
        stable_next  = stable_eff;
        pending_next = pending_reg;
        start_next   = start_reg;
        press        = 1'b0;
        if (level == stable_eff) begin
            pending_next = 1'b0;
        end else if (!pending_reg) begin
            pending_next = 1'b1;
            start_next   = now;
        end else if (elapsed >= TICK_BITS'(hold_ticks)) begin
            stable_next  = level;
            pending_next = 1'b0;
            press        = !level;
        end
    end

    // Hold state between polls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stable_reg  <= 1'b1;
            pending_reg <= 1'b0;
        end else if (ctl.advance) begin
            stable_reg  <= stable_next;
            pending_reg <= pending_next;
        end
    end

    // Start time carries no reset; read only while pending
    always_ff @(posedge aclk) begin
        if (ctl.advance) begin
            start_reg <= start_next;
        end
    end

endmodule

// File: rtl/bdpd_presence.sv
// Area-clear timing, detection arming and object event logic.
// Depends on bdpd_pkg for the poll control struct and config width.
module bdpd_presence #(
    parameter int TICK_BITS = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  bdpd_pkg::poll_ctl_t                ctl,
    input  logic                               present,
    input  logic                               run,
    input  logic [TICK_BITS-1:0]               now,
    input  logic [bdpd_pkg::CFG_DATA_BITS-1:0] clear_ticks,
    input  logic [bdpd_pkg::CFG_DATA_BITS-1:0] detect_hold_ticks,
    output logic                               area_empty,
    output logic                               ev_object,
    output logic                               armed_now
);

    logic                 prev_reg;
    logic                 clear_pend_reg, clear_pend_next;
    logic [TICK_BITS-1:0] clear_start_reg, clear_start_next;
    logic                 hold_pend_reg, hold_pend_next;
    logic [TICK_BITS-1:0] hold_start_reg, hold_start_next;
    logic                 armed_reg, armed_next;
    logic                 prev_eff;
    logic [TICK_BITS-1:0] clear_elapsed;
    logic [TICK_BITS-1:0] hold_elapsed;

    assign prev_eff      = ctl.first ? present : prev_reg;
    assign clear_elapsed = now - clear_start_reg;
    assign hold_elapsed  = now - hold_start_reg;

    // Area clear interval, then object detection on the updated arming
    always_comb begin
        clear_pend_next  = clear_pend_reg;
        clear_start_next = clear_start_reg;
        hold_pend_next   = hold_pend_reg;
        hold_start_next  = hold_start_reg;
        armed_next       = armed_reg;
        area_empty       = 1'b0;
        ev_object        = 1'b0;

        if (!present) begin
            if (!clear_pend_reg) begin
                clear_pend_next  = 1'b1;
                clear_start_next = now;
            end else if (clear_elapsed >= TICK_BITS'(clear_ticks)) begin
                area_empty      = 1'b1;
                clear_pend_next = 1'b0;
                if (run) begin
                    armed_next = 1'b1;
                end
            end
        end else begin
            clear_pend_next = 1'b0;
        end

        if (present && run && armed_next) begin
            if (!prev_eff) begin
                ev_object      = 1'b1;
                armed_next     = 1'b0;
                hold_pend_next = 1'b0;
            end else if (!hold_pend_reg) begin
                hold_pend_next  = 1'b1;
                hold_start_next = now;
            end else if (hold_elapsed >= TICK_BITS'(detect_hold_ticks)) begin
                ev_object      = 1'b1;
                armed_next     = 1'b0;
                hold_pend_next = 1'b0;
            end
        end else begin
            hold_pend_next = 1'b0;
        end
    end

    assign armed_now = armed_next;

    // Hold flags between polls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg       <= 1'b0;
            clear_pend_reg <= 1'b0;
            hold_pend_reg  <= 1'b0;
            armed_reg      <= 1'b1;
        end else if (ctl.advance) begin
            prev_reg       <= present;
            clear_pend_reg <= clear_pend_next;
            hold_pend_reg  <= hold_pend_next;
            armed_reg      <= armed_next;
        end
    end

    // Start times carry no reset; read only while their flag is set
    always_ff @(posedge aclk) begin
        if (ctl.advance) begin
            clear_start_reg <= clear_start_next;
            hold_start_reg  <= hold_start_next;
        end
    end

endmodule
